[rtl/ssp_pkg.sv]
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared types and constants of the servo status packet parser.
// ----------------------------------------------------------------------------
package ssp_pkg;

  localparam int WAIT_W = 7;

  localparam logic [7:0]        HEADER_BYTE  = 8'hFF;
  localparam logic [7:0]        ALL_CALL_ID  = 8'hFE;
  localparam logic [WAIT_W-1:0] MIN_WAIT     = 7'd6;
  localparam logic [7:0]        FRAME_EXTRA  = 8'd4;
  localparam logic [7:0]        MIN_LEN      = 8'd2;
  localparam logic [7:0]        MAX_PARAMS   = 8'd58;

  localparam logic [1:0] CMD_ARM     = 2'd0;
  localparam logic [1:0] CMD_BYTE    = 2'd1;
  localparam logic [1:0] CMD_TIMEOUT = 2'd2;

  localparam logic [1:0] STAT_SUCCESS   = 2'd0;
  localparam logic [1:0] STAT_CORRUPT   = 2'd1;
  localparam logic [1:0] STAT_TIMEOUT   = 2'd2;
  localparam logic [1:0] STAT_NOT_ARMED = 2'd3;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_LOOP   = 9'b000000010,
    S_SCAN   = 9'b000000100,
    S_ID     = 9'b000001000,
    S_LEN    = 9'b000010000,
    S_SUM    = 9'b000100000,
    S_CHK    = 9'b001000000,
    S_EMIT   = 9'b010000000,
    S_SINGLE = 9'b100000000
  } ssp_state_t;

endpackage

[rtl/servo_status_packet_parser.sv]
// ----------------------------------------------------------------------------
// servo_status_packet_parser
// Collects status packet bytes in a circular buffer, finds the header, checks id,
// length and checksum; streams one result per parameter byte, or a single one.
// ----------------------------------------------------------------------------
// An arm that waits for a reply, or an ignored item, is taken and the parser
// stays idle; a timeout, or an arm that is answered at once, gives a single
// result as soon as the output side is free. A received byte that does not
// complete the wait length is stored while there is room. Once the wait length
// is held, a small sequencer walks the buffer through its single read port:
// header scan over up to the held bytes, id and length reads, then the checksum
// run over length+1 bytes and the checksum byte itself. A good packet then
// streams one result per parameter byte (a single result if it has none) while
// the output side takes them. No input item is taken while the sequencer runs;
// the next input item is taken once the last result is in the output register.
// ----------------------------------------------------------------------------
module servo_status_packet_parser #(
  parameter int BUFFER_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,   // expected_id
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,      // rx_byte
  input  logic [1:0] in_tuser,      // cmd
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [31:0] out_tdata,    // status, error_bits, param_count, param_index,
                                    // param_byte, zero pad
  output logic       out_tlast
);
  import ssp_pkg::*;

  localparam int AW   = $clog2(BUFFER_BYTES);
  localparam int CW   = $clog2(BUFFER_BYTES + 1);
  localparam int SW   = CW + 1;
  localparam int CMPW = (CW > WAIT_W) ? CW : WAIT_W;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                             input logic [CW-1:0] b);
    logic [SW-1:0] s;
    s = SW'(a) + SW'(b);
    if (s >= SW'(BUFFER_BYTES)) begin
      s = s - SW'(BUFFER_BYTES);
    end
    return s[AW-1:0];
  endfunction

  logic [7:0] mem [BUFFER_BYTES];
  logic [7:0] rdata_r;

  ssp_state_t        state_r, state_nxt;
  logic              armed_r, armed_nxt;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic [WAIT_W-1:0] wait_r, wait_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     off_r, off_nxt;
  logic              dv_r, dv_nxt;
  logic              prev_ff_r, prev_ff_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic [7:0]        err_r, err_nxt;
  logic [5:0]        pidx_r, pidx_nxt;
  logic [1:0]        stat_r, stat_nxt;
  logic [7:0]        exp_id_r;

  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_status_r, out_status_nxt;
  logic [7:0] out_err_r, out_err_nxt;
  logic [5:0] out_cnt_r, out_cnt_nxt;
  logic [5:0] out_idx_r, out_idx_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;

  logic          in_acc;
  logic          out_free;
  logic          mem_we;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic          drop_en;
  logic [CW-1:0] drop_n;
  logic [7:0]    len;
  logic          len_bad;
  logic [WAIT_W-1:0] total;
  logic [5:0]    par_cnt;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign wr_addr = wrap_add(head_r, fill_r);
  assign rd_addr = wrap_add(head_r, off_r);
  assign mem_we  = in_acc && (in_tuser == CMD_BYTE) && armed_r &&
                   (fill_r < CW'(BUFFER_BYTES));

  assign len     = rdata_r;
  assign len_bad = (len < MIN_LEN) ||
                   ((9'(len) + 9'(FRAME_EXTRA)) > 9'(BUFFER_BYTES)) ||
                   ((len - MIN_LEN) > MAX_PARAMS);
  assign total   = WAIT_W'(len + FRAME_EXTRA);
  assign par_cnt = 6'(wait_r - MIN_WAIT);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= in_tdata;
    end
    rdata_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt      = state_r;
    armed_nxt      = armed_r;
    fill_nxt       = fill_r;
    wait_nxt       = wait_r;
    head_nxt       = head_r;
    off_nxt        = off_r;
    dv_nxt         = dv_r;
    prev_ff_nxt    = prev_ff_r;
    sum_nxt        = sum_r;
    err_nxt        = err_r;
    pidx_nxt       = pidx_r;
    stat_nxt       = stat_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_err_nxt    = out_err_r;
    out_cnt_nxt    = out_cnt_r;
    out_idx_nxt    = out_idx_r;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    drop_en        = 1'b0;
    drop_n         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_tuser)
            CMD_ARM: begin
              fill_nxt = '0;
              head_nxt = '0;
              wait_nxt = MIN_WAIT;
              if (exp_id_r == ALL_CALL_ID) begin
                armed_nxt = 1'b0;
                stat_nxt  = STAT_SUCCESS;
                err_nxt   = '0;
                state_nxt = S_SINGLE;
              end else begin
                armed_nxt = 1'b1;
              end
            end
            CMD_BYTE: begin
              if (armed_r) begin
                if (fill_r < CW'(BUFFER_BYTES)) begin
                  fill_nxt = fill_r + CW'(1);
                end
                state_nxt = S_LOOP;
              end
            end
            CMD_TIMEOUT: begin
              if (!armed_r) begin
                stat_nxt = STAT_NOT_ARMED;
              end else if (fill_r == '0) begin
                stat_nxt = STAT_TIMEOUT;
              end else begin
                stat_nxt = STAT_CORRUPT;
              end
              armed_nxt = 1'b0;
              err_nxt   = '0;
              state_nxt = S_SINGLE;
            end
            default: begin
            end
          endcase
        end
      end

      S_LOOP: begin
        if (CMPW'(fill_r) >= CMPW'(wait_r)) begin
          off_nxt     = '0;
          prev_ff_nxt = 1'b0;
          dv_nxt      = 1'b0;
          state_nxt   = S_SCAN;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_SCAN: begin
        dv_nxt = !dv_r;
        if (dv_r) begin
          if (prev_ff_r && (rdata_r == HEADER_BYTE)) begin
            if (off_r == CW'(1)) begin
              off_nxt   = CW'(2);
              state_nxt = S_ID;
            end else begin
              drop_en   = 1'b1;
              drop_n    = off_r - CW'(1);
              state_nxt = S_LOOP;
            end
          end else if ((off_r + CW'(1)) == fill_r) begin
            drop_en   = 1'b1;
            drop_n    = off_r;
            state_nxt = S_LOOP;
          end else begin
            prev_ff_nxt = (rdata_r == HEADER_BYTE);
            off_nxt     = off_r + CW'(1);
          end
        end
      end

      S_ID: begin
        dv_nxt = !dv_r;
        if (dv_r) begin
          if (rdata_r != exp_id_r) begin
            drop_en   = 1'b1;
            drop_n    = CW'(1);
            state_nxt = S_LOOP;
          end else begin
            off_nxt   = CW'(3);
            state_nxt = S_LEN;
          end
        end
      end

      S_LEN: begin
        dv_nxt = !dv_r;
        if (dv_r) begin
          if (len_bad) begin
            armed_nxt = 1'b0;
            stat_nxt  = STAT_CORRUPT;
            err_nxt   = '0;
            state_nxt = S_SINGLE;
          end else begin
            wait_nxt = total;
            if (CMPW'(fill_r) < CMPW'(total)) begin
              state_nxt = S_IDLE;
            end else begin
              sum_nxt   = '0;
              off_nxt   = CW'(2);
              state_nxt = S_SUM;
            end
          end
        end
      end

      S_SUM: begin
        dv_nxt = !dv_r;
        if (dv_r) begin
          sum_nxt = sum_r + rdata_r;
          if (off_r == CW'(4)) begin
            err_nxt = rdata_r;
          end
          if (off_r == CW'(wait_r - WAIT_W'(2))) begin
            off_nxt   = CW'(wait_r - WAIT_W'(1));
            state_nxt = S_CHK;
          end else begin
            off_nxt = off_r + CW'(1);
          end
        end
      end

      S_CHK: begin
        dv_nxt = !dv_r;
        if (dv_r) begin
          armed_nxt = 1'b0;
          if (rdata_r != ~sum_r) begin
            stat_nxt  = STAT_CORRUPT;
            err_nxt   = '0;
            state_nxt = S_SINGLE;
          end else if (par_cnt == '0) begin
            stat_nxt  = STAT_SUCCESS;
            state_nxt = S_SINGLE;
          end else begin
            off_nxt   = CW'(5);
            pidx_nxt  = '0;
            state_nxt = S_EMIT;
          end
        end
      end

      S_EMIT: begin
        if (!dv_r) begin
          dv_nxt = 1'b1;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_SUCCESS;
          out_err_nxt    = err_r;
          out_cnt_nxt    = par_cnt;
          out_idx_nxt    = pidx_r;
          out_byte_nxt   = rdata_r;
          out_last_nxt   = ((pidx_r + 6'd1) == par_cnt);
          dv_nxt         = 1'b0;
          if ((pidx_r + 6'd1) == par_cnt) begin
            state_nxt = S_IDLE;
          end else begin
            pidx_nxt = pidx_r + 6'd1;
            off_nxt  = off_r + CW'(1);
          end
        end
      end

      S_SINGLE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = stat_r;
          out_err_nxt    = err_r;
          out_cnt_nxt    = '0;
          out_idx_nxt    = '0;
          out_byte_nxt   = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (drop_en) begin
      head_nxt = wrap_add(head_r, drop_n);
      fill_nxt = fill_r - drop_n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      armed_r     <= 1'b0;
      fill_r      <= '0;
      wait_r      <= MIN_WAIT;
      head_r      <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      exp_id_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      armed_r     <= armed_nxt;
      fill_r      <= fill_nxt;
      wait_r      <= wait_nxt;
      head_r      <= head_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        exp_id_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    off_r        <= off_nxt;
    prev_ff_r    <= prev_ff_nxt;
    sum_r        <= sum_nxt;
    err_r        <= err_nxt;
    pidx_r       <= pidx_nxt;
    stat_r       <= stat_nxt;
    out_status_r <= out_status_nxt;
    out_err_r    <= out_err_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_idx_r    <= out_idx_nxt;
    out_byte_r   <= out_byte_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_byte_r, out_idx_r, out_cnt_r, out_err_r, out_status_r};
  assign out_tlast  = out_last_r;

endmodule
